// ===== src/thlm_pkg.sv =====
// thlm_pkg: constants, register indexes and control types of the trigger hold-off meter
// used by thlm_ctrl, thlm_dp and trigger_holdoff_length_meter_top
// no dependencies
package thlm_pkg;

    // channel counts
    localparam int NUM_TRIGGERS = 5;
    localparam int NUM_DIGITAL  = 3;
    localparam int IDX_W        = $clog2(NUM_TRIGGERS);

    // field widths
    localparam int CH_W      = 3;
    localparam int TIME_W    = 32;
    localparam int PIN_W     = 3;
    localparam int IDLE_W    = 2;
    localparam int LEN_W     = 16;
    localparam int MAXLEN_W  = 15;
    localparam int PAUSE_W   = 16;
    localparam int HOLD_W    = 16;
    localparam int MASK_W    = 5;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PAUSE_CH0     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PAUSE_CH4     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_LEVELS = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LENGTH    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_BUZZER_HOLD   = 3'd7;

    // reset values
    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 15'd32767;
    localparam logic [HOLD_W-1:0]   HOLD_RESET   = 16'd500;

    // input action and output kind codes
    localparam logic ACT_SHOT   = 1'b0;
    localparam logic ACT_POLL   = 1'b1;
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // length reported for an over-long pulse
    localparam logic [LEN_W-1:0] LEN_OVER = 16'hFFFF;

    // digital channels as a mask over an 8-bit padded pin vector
    localparam logic [7:0] DIG_MASK = 8'((1 << NUM_DIGITAL) - 1);

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture input word, clear scan state
        logic shot;       // qualify and record a shot edge
        logic scan;       // evaluate one channel of a poll
        logic buzz;       // update buzzer after the scan
        logic emit_rep;   // load next release report into output stage
        logic emit_stat;  // load status word into output stage
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic poll;       // captured word is a poll
        logic scan_last;  // scan is on the last channel
        logic done_any;   // release reports still to send
        logic out_free;   // output stage can take a word
    } st_t;

endpackage

// ===== src/thlm_ctrl.sv =====
// thlm_ctrl: sequencing state machine for shots and polls
// depends on thlm_pkg (cmd_t, st_t)
module thlm_ctrl
    import thlm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  st_t  st,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SHOT = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_BUZZ = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_STAT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SHOT;
                end
            end
            S_SHOT:
            begin
                // the captured word decides: shot edge or poll
                if (st.poll)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.shot   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.scan_last)
                begin
                    state_next = S_BUZZ;
                end
            end
            S_BUZZ:
            begin
                cmd.buzz   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!st.done_any)
                begin
                    state_next = S_STAT;
                end
                else if (st.out_free)
                begin
                    cmd.emit_rep = 1'b1;
                end
            end
            S_STAT:
            begin
                if (st.out_free)
                begin
                    cmd.emit_stat = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/thlm_dp.sv =====
// thlm_dp: configuration registers, per-channel state, pulse meter, buzzer and output stage
// depends on thlm_pkg (constants, cmd_t, st_t)
module thlm_dp
    import thlm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  in_user,
    input  cmd_t                  cmd,
    output st_t                   st,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_user,
    output logic                  out_last
);

    // configuration
    logic [PAUSE_W-1:0]  pause_reg [NUM_TRIGGERS];
    logic [PIN_W-1:0]    act_reg;
    logic [MAXLEN_W-1:0] maxlen_reg;
    logic [HOLD_W-1:0]   hold_reg;

    // captured input word
    logic              action_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] stamp_reg;
    logic [PIN_W-1:0]  pins_reg;
    logic [IDLE_W-1:0] idle_reg;

    // channel state
    logic [TIME_W-1:0]       last_shot_reg [NUM_TRIGGERS];
    logic [TIME_W-1:0]       tag_reg [NUM_TRIGGERS];
    logic [LEN_W-1:0]        len_reg [NUM_TRIGGERS];
    logic [NUM_TRIGGERS-1:0] pending_reg;
    logic [NUM_TRIGGERS-1:0] done_reg;
    logic [IDX_W-1:0]        scan_reg;
    logic                    buzzer_reg;
    logic [TIME_W-1:0]       bstart_reg;

    // output stage
    logic                  oval_reg;
    logic [OUT_DATA_W-1:0] odata_reg;
    logic                  ouser_reg;

    logic [IDX_W-1:0]  addr;
    logic              ch_ok;
    logic [TIME_W-1:0] last_rd;
    logic [PAUSE_W-1:0] pause_rd;
    logic [TIME_W-1:0] since;
    logic              shot_ok;
    logic              over;
    logic              rel;
    logic [LEN_W-1:0]  len_val;
    logic [7:0]        pins8;
    logic [7:0]        act8;
    logic [7:0]        idle8;
    logic              dig_active;
    logic [TIME_W-1:0] buzz_age;
    logic [IDX_W-1:0]  emit_idx;
    logic [7:0]        pend8;
    logic [MASK_W-1:0] pmask;
    logic              out_free;

    // shared channel-state read port: shot channel or scan index
    assign addr     = cmd.scan ? scan_reg : ch_reg[IDX_W-1:0];
    assign ch_ok    = {1'b0, ch_reg} < (CH_W+1)'(NUM_TRIGGERS);
    assign last_rd  = last_shot_reg[addr];
    assign pause_rd = pause_reg[addr];
    assign since    = now_reg - last_rd;

    // hold-off qualification
    assign shot_ok = ch_ok && (since > TIME_W'(pause_rd));

    // pulse length and release decision for the scanned channel
    assign pins8 = {{(8-PIN_W){1'b0}}, pins_reg};
    assign act8  = {{(8-PIN_W){1'b0}}, act_reg};
    assign idle8 = {{(8-IDLE_W){1'b0}}, idle_reg};
    assign over    = since > TIME_W'(maxlen_reg);
    assign len_val = over ? LEN_OVER : since[LEN_W-1:0];

    always_comb
    begin
        rel = over;
        if (32'(scan_reg) < NUM_DIGITAL)
        begin
            if (pins8[scan_reg] != act8[scan_reg])
            begin
                rel = 1'b1;
            end
        end
        else if (32'(scan_reg) == NUM_DIGITAL)
        begin
            if (idle8[0])
            begin
                rel = 1'b1;
            end
        end
        else if (32'(scan_reg) == NUM_DIGITAL + 1)
        begin
            if (idle8[1])
            begin
                rel = 1'b1;
            end
        end
        else
        begin
            rel = 1'b1;
        end
    end

    // any digital pin at its active level
    assign dig_active = |(~(pins8 ^ act8) & DIG_MASK);
    assign buzz_age   = now_reg - bstart_reg;

    // lowest channel with a report still to send
    always_comb
    begin
        emit_idx = '0;
        for (int i = NUM_TRIGGERS - 1; i >= 0; i--)
        begin
            if (done_reg[i])
            begin
                emit_idx = IDX_W'(i);
            end
        end
    end

    assign pend8 = 8'(pending_reg);
    assign pmask = pend8[MASK_W-1:0];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TRIGGERS; i++)
            begin
                pause_reg[i] <= '0;
            end
            act_reg    <= '0;
            maxlen_reg <= MAXLEN_RESET;
            hold_reg   <= HOLD_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_ACTIVE_LEVELS)
            begin
                act_reg <= cfg_wdata[PIN_W-1:0];
            end
            else if (cfg_addr == REG_MAX_LENGTH)
            begin
                maxlen_reg <= cfg_wdata[MAXLEN_W-1:0];
            end
            else if (cfg_addr == REG_BUZZER_HOLD)
            begin
                hold_reg <= cfg_wdata[HOLD_W-1:0];
            end
            else if (cfg_addr >= REG_PAUSE_CH0 && cfg_addr <= REG_PAUSE_CH4 &&
                     32'(cfg_addr) < NUM_TRIGGERS)
            begin
                pause_reg[cfg_addr[IDX_W-1:0]] <= cfg_wdata[PAUSE_W-1:0];
            end
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg    <= in_data[2:0];
            now_reg   <= in_data[34:3];
            stamp_reg <= in_data[66:35];
            pins_reg  <= in_data[69:67];
            idle_reg  <= in_data[71:70];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            action_reg <= ACT_SHOT;
        end
        else if (cmd.load)
        begin
            action_reg <= in_user;
        end
    end

    // time tags and lengths
    always_ff @(posedge clk)
    begin
        if (cmd.shot && shot_ok)
        begin
            tag_reg[addr] <= stamp_reg;
        end
        if (cmd.scan)
        begin
            len_reg[addr] <= len_val;
        end
    end

    // channel state, scan walk and buzzer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TRIGGERS; i++)
            begin
                last_shot_reg[i] <= '0;
            end
            pending_reg <= '0;
            done_reg    <= '0;
            scan_reg    <= '0;
            buzzer_reg  <= 1'b0;
            bstart_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                done_reg <= '0;
                scan_reg <= '0;
            end
            if (cmd.shot && shot_ok)
            begin
                last_shot_reg[addr] <= now_reg;
                pending_reg[addr]   <= 1'b1;
                buzzer_reg          <= 1'b1;
            end
            if (cmd.scan)
            begin
                scan_reg <= scan_reg + 1'b1;
                if (pending_reg[addr] && rel)
                begin
                    last_shot_reg[addr] <= now_reg;
                    pending_reg[addr]   <= 1'b0;
                    done_reg[addr]      <= 1'b1;
                end
            end
            if (cmd.buzz && buzzer_reg)
            begin
                if (pending_reg == '0)
                begin
                    if (!dig_active && buzz_age >= TIME_W'(hold_reg))
                    begin
                        buzzer_reg <= 1'b0;
                        bstart_reg <= '0;
                    end
                end
                else if (bstart_reg == '0)
                begin
                    bstart_reg <= (now_reg == '0) ? TIME_W'(1) : now_reg;
                end
            end
            if (cmd.emit_rep)
            begin
                done_reg[emit_idx] <= 1'b0;
            end
        end
    end

    // output stage
    assign out_free = !oval_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oval_reg <= 1'b0;
        end
        else if (cmd.emit_rep || cmd.emit_stat)
        begin
            oval_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            oval_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_rep)
        begin
            odata_reg <= {7'b0, buzzer_reg, pmask, tag_reg[emit_idx], len_reg[emit_idx],
                          CH_W'(emit_idx)};
            ouser_reg <= KIND_REPORT;
        end
        else if (cmd.emit_stat)
        begin
            odata_reg <= {7'b0, buzzer_reg, pmask, {TIME_W{1'b0}}, {LEN_W{1'b0}},
                          {CH_W{1'b0}}};
            ouser_reg <= KIND_STATUS;
        end
    end

    assign out_valid = oval_reg;
    assign out_data  = odata_reg;
    assign out_user  = ouser_reg;
    assign out_last  = (ouser_reg == KIND_STATUS);

    // status to the controller
    assign st.poll      = (action_reg == ACT_POLL);
    assign st.scan_last = (scan_reg == IDX_W'(NUM_TRIGGERS - 1));
    assign st.done_any  = |done_reg;
    assign st.out_free  = out_free;

endmodule

// ===== src/trigger_holdoff_length_meter_top.sv =====
// Trigger hold-off qualifier and pulse-length meter for five channels (three digital
// pins, rangefinder, analog trigger). A shot word (tuser 0) is checked against the
// channel's hold-off and, if taken, records its time tag, marks the channel pending
// and turns the buzzer on; it yields no output word. A poll word (tuser 1)
// walks the channels one per cycle through the shared channel-state read port,
// updates the buzzer, then sends one report per released channel and a status word
// with tlast set; each word waits while the output stalls.
// pending_mask and buzzer in every word of a poll show the state at its end. The
// next input word is taken while the status word still waits at the output.
// depends on thlm_pkg, thlm_ctrl, thlm_dp
module trigger_holdoff_length_meter_top
    import thlm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // channel[2:0], now_ms[34:3], stamp[66:35], pin_levels[69:67], aux_idle[71:70]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // report_channel[2:0], length_ms[18:3], shot_tag[50:19], pending_mask[55:51],
    // buzzer[56], zero[63:57]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    cmd_t cmd;
    st_t  st;

    // sequencer
    thlm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath
    thlm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .cmd       (cmd),
        .st        (st),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    // only the status word closes a poll
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_STATUS)))
        else $error("tlast does not match word kind");

    // a released channel is no longer pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_REPORT) |->
            (((m_axis_tdata[55:51] >> m_axis_tdata[2:0]) & 5'd1) == 5'd0))
        else $error("reported channel still pending");

    // no new word is taken while a poll still has reports to deliver
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_REPORT) |-> !s_axis_tready)
        else $error("input taken during report delivery");

endmodule
